/* rtl/table_driven_dfa_matcher_unit_defines.svh */
// Assertion macros shared by the DFA matcher RTL.
`ifndef TABLE_DRIVEN_DFA_MATCHER_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_DFA_MATCHER_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define TDDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define TDDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tddm_pkg.sv */
// Shared types and constants for the DFA matcher.
package tddm_pkg;

  // Default depth of the transition list.
  localparam int TABLE_ENTRIES_DEF = 64;

  // Field widths.
  localparam int STATE_W    = 6;
  localparam int SYM_W      = 8;
  localparam int FUNC_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int MASK_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 2'd1;

  // Item kinds carried on the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SYM = 2'd1,
    FUNC_END = 2'd2
  } func_t;

  // Result codes.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_STORED = 2'd0,
    OUT_FULL   = 2'd1,
    OUT_REJECT = 2'd2,
    OUT_ACCEPT = 2'd3
  } outcome_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } seq_state_t;

  // One transition entry as held in the list.
  typedef struct packed {
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
  } entry_t;

endpackage

/* rtl/tddm_table.sv */
// Transition list storage: one write port and one registered read port.
module tddm_table
  import tddm_pkg::*;
#(
  parameter int  DEPTH = TABLE_ENTRIES_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_entry,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry
);

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  // Append writes from the add path.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Read data is registered; it belongs to the address of the previous cycle.
  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

/* rtl/table_driven_dfa_matcher_unit.sv */
// Programmable DFA string acceptor: top level with sequencer and result register.
//
// Software appends transition entries (from state, symbol, to state) with add
// items, then feeds strings one symbol per item and closes each with an end
// item. Add and end items each give one result; a symbol item gives no result
// and holds the input while the single read port of the transition list is
// walked one entry per cycle in list order until the first entry that matches
// the current state and symbol. A symbol that arrives while the string is
// already dead does not start a walk. The configuration port is always ready;
// writing the start state also begins a new string. A new item is taken in the
// same cycle that a waiting result transfers.
module table_driven_dfa_matcher_unit
  import tddm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] from_state, [13:6] symbol, [19:14] to_state, [23:20] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]     in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] outcome, [7:2] end_state
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MASK_W-1:0]     cfg_data
);

  `include "table_driven_dfa_matcher_unit_defines.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // Registers.
  seq_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               dead_r, dead_nxt;
  logic [STATE_W-1:0] start_r, start_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  outcome_t           outcome_r, outcome_nxt;
  logic [STATE_W-1:0] end_state_r, end_state_nxt;

  // Unpacked input fields.
  func_t              in_func;
  logic [STATE_W-1:0] in_from;
  logic [SYM_W-1:0]   in_sym;
  logic [STATE_W-1:0] in_to;

  // Control.
  logic   in_xfer;
  logic   issue;
  logic   hit;
  logic   full;
  logic   wr_en;
  entry_t wr_entry;
  entry_t rd_entry;

  assign in_func = func_t'(in_tuser);
  assign in_from = in_tdata[5:0];
  assign in_sym  = in_tdata[13:6];
  assign in_to   = in_tdata[19:14];

  assign wr_entry = '{to_state: in_to, symbol: in_sym, from_state: in_from};

  // Transition list storage.
  tddm_table #(
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count_r[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (scan_r[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  // Sequencer outputs and handshake control.
  always_comb begin
    in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
    in_xfer   = in_tvalid && in_tready;
    full      = (count_r == FULL_CNT);
    wr_en     = in_xfer && (in_func == FUNC_ADD) && !full;
    issue     = (state_r == S_SEARCH) && (scan_r < count_r);
    hit       = (state_r == S_SEARCH) && cmp_vld_r &&
                (rd_entry.from_state == cur_r) && (rd_entry.symbol == sym_r);
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_func == FUNC_SYM) && !dead_r) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || !issue) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and string state updates.
  always_comb begin
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    start_nxt     = start_r;
    mask_nxt      = mask_r;
    sym_nxt       = sym_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    out_valid_nxt = out_valid_r;
    outcome_nxt   = outcome_r;
    end_state_nxt = end_state_r;

    // A waiting result leaves on its transfer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Accepted items.
    if (in_xfer) begin
      case (in_func)
        FUNC_ADD: begin
          out_valid_nxt = 1'b1;
          end_state_nxt = '0;
          if (full) begin
            outcome_nxt = OUT_FULL;
          end else begin
            outcome_nxt = OUT_STORED;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        FUNC_SYM: begin
          if (!dead_r) begin
            sym_nxt     = in_sym;
            scan_nxt    = '0;
            cmp_vld_nxt = 1'b0;
          end
        end
        FUNC_END: begin
          out_valid_nxt = 1'b1;
          if (dead_r) begin
            outcome_nxt   = OUT_REJECT;
            end_state_nxt = '0;
          end else begin
            outcome_nxt   = mask_r[cur_r] ? OUT_ACCEPT : OUT_REJECT;
            end_state_nxt = cur_r;
          end
          cur_nxt  = start_r;
          dead_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // List walk: one read issued and one compare per cycle.
    if (state_r == S_SEARCH) begin
      cmp_vld_nxt = issue;
      if (issue) begin
        scan_nxt = scan_r + CNT_W'(1);
      end
      if (hit) begin
        cur_nxt = rd_entry.to_state;
      end else if (!issue) begin
        dead_nxt = 1'b1;
      end
    end

    // Register writes; the start state also begins a new string.
    if (cfg_valid) begin
      case (cfg_index)
        CFG_START_STATE: begin
          start_nxt = cfg_data[STATE_W-1:0];
          cur_nxt   = cfg_data[STATE_W-1:0];
          dead_nxt  = 1'b0;
        end
        CFG_FINAL_MASK: begin
          mask_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      start_r     <= '0;
      mask_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      start_r     <= start_nxt;
      mask_r      <= mask_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    scan_r      <= scan_nxt;
    outcome_r   <= outcome_nxt;
    end_state_r <= end_state_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {end_state_r, outcome_r};

  // Checks on the sequencer and result path.
  `TDDM_ASSERT(a_count_bound, count_r <= FULL_CNT, "entry count beyond list depth")
  `TDDM_ASSERT(a_busy_search, (state_r == S_SEARCH) |-> !in_tready,
               "input taken during a list walk")
  `TDDM_ASSERT_NEXT(a_hit_alive, hit, !dead_r, "string dead after a matching entry")
  `TDDM_ASSERT(a_result_cause, $rose(out_tvalid) |-> $past(in_tvalid && in_tready),
               "result raised without an accepted item")

endmodule
